// File: src/itp_pkg.sv
package itp_pkg;

	// Operator stack geometry.
	localparam int STACK_DEPTH = 32;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	// Characters with a meaning of their own.
	localparam logic [7:0] CH_POW = 8'h5E;
	localparam logic [7:0] CH_DIV = 8'h2F;
	localparam logic [7:0] CH_MUL = 8'h2A;
	localparam logic [7:0] CH_ADD = 8'h2B;
	localparam logic [7:0] CH_SUB = 8'h2D;
	localparam logic [7:0] CH_OPEN = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;

	// Commands from the sequencer to the stack.
	typedef struct packed {
		logic       push;
		logic       pop;
		logic       clear;
		logic [7:0] data;
	} stk_cmd_t;

	// Stack status seen by the sequencer.
	typedef struct packed {
		logic [CNT_W-1:0] open_cnt;
		logic [7:0]       top;
		logic             empty;
		logic             full;
	} stk_stat_t;

	// Binding strength of an operator, zero for anything else.
	function automatic logic [1:0] prec_of(input logic [7:0] c);
		logic [1:0] p;
		case (c)
			CH_POW:         p = 2'd3;
			CH_MUL, CH_DIV: p = 2'd2;
			CH_ADD, CH_SUB: p = 2'd1;
			default:        p = 2'd0;
		endcase
		return p;
	endfunction

	// True when the stacked operator top must be emitted before operator c.
	// The power operator groups to the right, so equal precedence keeps it.
	function automatic logic pops_before(input logic [7:0] top, input logic [7:0] c);
		logic [1:0] tp;
		logic [1:0] p;
		tp = prec_of(top);
		p = prec_of(c);
		return (tp != 2'd0) && ((tp > p) || ((tp == p) && (c != CH_POW)));
	endfunction

endpackage

// File: src/itp_ram.sv
module itp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/itp_stack.sv
module itp_stack (
	input  logic             clk,
	input  logic             arst_n,
	input  itp_pkg::stk_cmd_t  cmd,
	output itp_pkg::stk_stat_t stat
);
	import itp_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] open_q;
	logic [7:0]       top_q;
	logic             reload_q;
	logic             full;
	logic             empty;
	logic             do_push;
	logic             do_pop;
	logic [AW-1:0]    rd_cnt;
	logic [7:0]       rdata;

	assign full = (count_q == CNT_W'(STACK_DEPTH));
	assign empty = (count_q == '0);
	assign do_push = cmd.push && !full;
	assign do_pop = cmd.pop && !empty;

	// After a pop the entry below the old top becomes the new top.
	assign rd_cnt = count_q[AW-1:0] - AW'(2);

	itp_ram #(
		.WIDTH(8),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (do_push),
		.waddr(count_q[AW-1:0]),
		.wdata(cmd.data),
		.raddr(rd_cnt),
		.rdata(rdata)
	);

	// Fill count, count of open parentheses held, and the reload flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			open_q <= '0;
			reload_q <= 1'b0;
		end else if (cmd.clear) begin
			count_q <= '0;
			open_q <= '0;
			reload_q <= 1'b0;
		end else if (do_push) begin
			count_q <= count_q + CNT_W'(1);
			open_q <= open_q + CNT_W'(cmd.data == CH_OPEN);
			reload_q <= 1'b0;
		end else if (do_pop) begin
			count_q <= count_q - CNT_W'(1);
			open_q <= open_q - CNT_W'(top_q == CH_OPEN);
			reload_q <= (count_q != CNT_W'(1));
		end else begin
			reload_q <= 1'b0;
		end
	end

	// Cached top entry, refreshed from the registered memory read after a pop.
	always_ff @(posedge clk) begin
		if (do_push) begin
			top_q <= cmd.data;
		end else if (reload_q) begin
			top_q <= rdata;
		end
	end

	assign stat.open_cnt = open_q;
	assign stat.top = top_q;
	assign stat.empty = empty;
	assign stat.full = full;

endmodule

// File: src/infix_to_postfix_converter.sv
// Shunting-yard converter: one infix character per request, postfix characters out,
// with a STACK_DEPTH-entry operator stack in a RAM and its top cached in a register.
// The block takes one character at a time and stalls its input until that character
// is done. Each operator that a character pops is emitted, then the registered stack
// read refreshes the top before the next step. A close paren pops operators until it
// finds its open paren. A character that ends a run then flushes the stack, and
// output stalls hold the block further.
// Each result passes through a one-entry hold register, so the final
// result of a run can carry end_of_run; a run whose last character yields nothing
// ends with one result that has has_char low. The error flag is the same on every
// result of a character and covers everything seen so far in the run.
module infix_to_postfix_converter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_in,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       has_char,
	output logic       end_of_run,
	output logic       error
);
	import itp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_CLOSE,
		S_OPER,
		S_WAIT,
		S_FINISH,
		S_FLUSH,
		S_END
	} state_t;

	typedef enum logic [2:0] {
		CLS_ALNUM,
		CLS_OPEN,
		CLS_CLOSE,
		CLS_OP,
		CLS_OTHER
	} cls_t;

	state_t state_q, state_d, ret_q, ret_d;
	cls_t cls_q, cls_in;
	logic [7:0] c_q;
	logic       last_q;
	logic       err_cur_q;
	logic       error_seen_q;
	logic       hold_valid_q;
	logic [7:0] hold_char_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       has_char_q;
	logic       end_q;
	logic       error_q;

	stk_cmd_t  stk_cmd;
	stk_stat_t stat;

	logic       out_free;
	logic       can_emit;
	logic       do_emit;
	logic [7:0] emit_char;
	logic       do_end;
	logic       accept;
	logic       err_item;
	logic       flush_err;
	logic [CNT_W-1:0] open_after;

	itp_stack u_stack (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (stk_cmd),
		.stat  (stat)
	);

	// Character class of the incoming request.
	always_comb begin
		if (char_in inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]}) begin
			cls_in = CLS_ALNUM;
		end else if (char_in == CH_OPEN) begin
			cls_in = CLS_OPEN;
		end else if (char_in == CH_CLOSE) begin
			cls_in = CLS_CLOSE;
		end else if (prec_of(char_in) != 2'd0) begin
			cls_in = CLS_OP;
		end else begin
			cls_in = CLS_OTHER;
		end
	end

	// The error of this character is known up front from the stack state.
	always_comb begin
		err_item = (cls_in == CLS_OTHER) ||
			((cls_in == CLS_OPEN) && stat.full) ||
			((cls_in == CLS_CLOSE) && (stat.open_cnt == '0)) ||
			((cls_in == CLS_OP) && stat.full && !pops_before(stat.top, char_in));
		open_after = stat.open_cnt
			+ CNT_W'((cls_in == CLS_OPEN) && !stat.full)
			- CNT_W'((cls_in == CLS_CLOSE) && (stat.open_cnt != '0));
		flush_err = last && (open_after != '0);
	end

	assign accept = (state_q == S_IDLE) && in_valid;
	assign out_free = !out_valid_q || !out_stall;
	assign can_emit = !hold_valid_q || out_free;

	// Sequencer decisions and stack commands.
	always_comb begin
		state_d = state_q;
		ret_d = ret_q;
		do_emit = 1'b0;
		emit_char = stat.top;
		do_end = 1'b0;
		stk_cmd = '0;
		stk_cmd.data = c_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (cls_q)
					CLS_ALNUM: begin
						if (can_emit) begin
							do_emit = 1'b1;
							emit_char = c_q;
							state_d = S_FINISH;
						end
					end
					CLS_OPEN: begin
						stk_cmd.push = 1'b1;
						state_d = S_FINISH;
					end
					CLS_CLOSE: state_d = S_CLOSE;
					CLS_OP: state_d = S_OPER;
					default: state_d = S_FINISH;
				endcase
			end
			S_CLOSE: begin
				if (stat.empty) begin
					state_d = S_FINISH;
				end else if (stat.top == CH_OPEN) begin
					stk_cmd.pop = 1'b1;
					state_d = S_WAIT;
					ret_d = S_FINISH;
				end else if (can_emit) begin
					do_emit = 1'b1;
					stk_cmd.pop = 1'b1;
					state_d = S_WAIT;
					ret_d = S_CLOSE;
				end
			end
			S_OPER: begin
				if (!stat.empty && pops_before(stat.top, c_q)) begin
					if (can_emit) begin
						do_emit = 1'b1;
						stk_cmd.pop = 1'b1;
						state_d = S_WAIT;
						ret_d = S_OPER;
					end
				end else begin
					stk_cmd.push = 1'b1;
					state_d = S_FINISH;
				end
			end
			S_WAIT: state_d = ret_q;
			S_FINISH: state_d = last_q ? S_FLUSH : S_END;
			S_FLUSH: begin
				if (stat.empty) begin
					state_d = S_END;
				end else if (stat.top == CH_OPEN) begin
					stk_cmd.pop = 1'b1;
					state_d = S_WAIT;
					ret_d = S_FLUSH;
				end else if (can_emit) begin
					do_emit = 1'b1;
					stk_cmd.pop = 1'b1;
					state_d = S_WAIT;
					ret_d = S_FLUSH;
				end
			end
			S_END: begin
				if (!(last_q || hold_valid_q)) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					do_end = 1'b1;
					stk_cmd.clear = last_q;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			error_seen_q <= 1'b0;
			hold_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
			if (accept) begin
				error_seen_q <= error_seen_q || err_item || flush_err;
			end else if (do_end && last_q) begin
				error_seen_q <= 1'b0;
			end
			if (do_emit) begin
				hold_valid_q <= 1'b1;
			end else if (do_end) begin
				hold_valid_q <= 1'b0;
			end
			if ((do_emit && hold_valid_q) || do_end) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request payload and result registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			c_q <= char_in;
			last_q <= last;
			cls_q <= cls_in;
			err_cur_q <= error_seen_q || err_item || flush_err;
		end
		if (do_emit) begin
			hold_char_q <= emit_char;
		end
		if (do_emit && hold_valid_q) begin
			out_char_q <= hold_char_q;
			has_char_q <= 1'b1;
			end_q <= 1'b0;
			error_q <= err_cur_q;
		end else if (do_end) begin
			out_char_q <= hold_valid_q ? hold_char_q : 8'h00;
			has_char_q <= hold_valid_q;
			end_q <= last_q;
			error_q <= err_cur_q;
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_char = out_char_q;
	assign has_char = has_char_q;
	assign end_of_run = end_q;
	assign error = error_q;

endmodule

// File: verif/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import itp_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 100;
	localparam int MAX_REPORTS = 10;

	// One postfix result as the block should present it.
	typedef struct packed {
		logic [7:0] ch;
		logic       has;
		logic       eor;
		logic       err;
	} postfix_res_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] char_in = 8'h00;
	logic       last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_char;
	logic       has_char;
	logic       end_of_run;
	logic       error;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int fault_count = 0;
	int items_sent = 0;
	int idle_cycles = 0;

	// Expected postfix output, oldest first.
	postfix_res_t postfix_q[$];

	// Shadow copy of the operator stack and the run's error flag.
	logic [7:0] op_stack [STACK_DEPTH];
	int         op_depth = 0;
	logic       run_err = 1'b0;

	// Characters of the expression that is about to be sent.
	logic [7:0] expr_chars[$];

	infix_to_postfix_converter uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_in(char_in),
		.last(last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char(out_char),
		.has_char(has_char),
		.end_of_run(end_of_run),
		.error(error)
	);

	always #4 clk = ~clk;

	// Binding strength of an operator; zero means not an operator.
	function automatic int bind_strength(input logic [7:0] c);
		if (c == CH_POW) return 3;
		if (c == CH_MUL || c == CH_DIV) return 2;
		if (c == CH_ADD || c == CH_SUB) return 1;
		return 0;
	endfunction

	function automatic bit is_operand(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
		       (c >= "0" && c <= "9");
	endfunction

	// A push onto a full stack is dropped and flags the run.
	function automatic void push_operator(input logic [7:0] c);
		if (op_depth < STACK_DEPTH) begin
			op_stack[op_depth] = c;
			op_depth++;
		end else begin
			run_err = 1'b1;
		end
	endfunction

	// Works out the postfix output caused by one accepted request.
	function automatic void convert_char(input logic [7:0] c, input logic fin);
		logic [7:0] emitted[$];
		logic [7:0] top;
		postfix_res_t r;
		bit matched;
		int p;
		int i;
		matched = 1'b0;
		p = bind_strength(c);
		if (is_operand(c)) begin
			emitted.push_back(c);
		end else if (c == CH_OPEN) begin
			push_operator(c);
		end else if (c == CH_CLOSE) begin
			while (op_depth > 0 && !matched) begin
				op_depth--;
				top = op_stack[op_depth];
				if (top == CH_OPEN) matched = 1'b1;
				else emitted.push_back(top);
			end
			if (!matched) run_err = 1'b1;
		end else if (p != 0) begin
			// Power groups to the right, so an equal power stays stacked.
			while (op_depth > 0 && bind_strength(op_stack[op_depth-1]) != 0 &&
			       (bind_strength(op_stack[op_depth-1]) > p ||
			        (bind_strength(op_stack[op_depth-1]) == p && c != CH_POW))) begin
				emitted.push_back(op_stack[op_depth-1]);
				op_depth--;
			end
			push_operator(c);
		end else begin
			run_err = 1'b1;
		end

		// The final character flushes the stack; a leftover open paren is an error.
		if (fin) begin
			while (op_depth > 0) begin
				op_depth--;
				top = op_stack[op_depth];
				if (top == CH_OPEN) run_err = 1'b1;
				else emitted.push_back(top);
			end
		end

		for (i = 0; i < emitted.size(); i++) begin
			r.ch = emitted[i];
			r.has = 1'b1;
			r.eor = fin && (i == emitted.size() - 1);
			r.err = run_err;
			postfix_q.push_back(r);
		end
		if (fin && emitted.size() == 0) begin
			r = '{ch: 8'h00, has: 1'b0, eor: 1'b1, err: run_err};
			postfix_q.push_back(r);
		end

		if (fin) begin
			op_depth = 0;
			run_err = 1'b0;
		end
	endfunction

	// Offers one request, with random idle cycles ahead of it, and waits until it is taken.
	task automatic send_char(input logic [7:0] c, input logic fin);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		char_in <= c;
		last <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		convert_char(c, fin);
		items_sent++;
	endtask

	// Sends the queued expression with last set on its final character.
	task automatic send_expression();
		int i;
		for (i = 0; i < expr_chars.size(); i++) begin
			send_char(expr_chars[i], i == expr_chars.size() - 1);
		end
		expr_chars.delete();
	endtask

	function automatic void queue_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) expr_chars.push_back(s[i]);
	endfunction

	function automatic logic [7:0] rand_operand();
		int k;
		k = $urandom_range(0, 61);
		if (k < 26) return 8'(8'h61 + k);
		if (k < 52) return 8'(8'h41 + (k - 26));
		return 8'(8'h30 + (k - 52));
	endfunction

	function automatic logic [7:0] rand_operator();
		case ($urandom_range(0, 4))
			0: return CH_POW;
			1: return CH_MUL;
			2: return CH_DIV;
			3: return CH_ADD;
			default: return CH_SUB;
		endcase
	endfunction

	// Well-formed infix text: operands joined by operators, some in parentheses.
	function automatic void build_infix(input int depth);
		int terms;
		int i;
		terms = $urandom_range(1, 4);
		for (i = 0; i < terms; i++) begin
			if (i > 0) expr_chars.push_back(rand_operator());
			// An operand is a plain character or a nested group in parentheses.
			if (depth > 0 && $urandom_range(0, 3) == 0) begin
				expr_chars.push_back(CH_OPEN);
				build_infix(depth - 1);
				expr_chars.push_back(CH_CLOSE);
			end else begin
				expr_chars.push_back(rand_operand());
			end
		end
	endfunction

	// Receiver: random stalls, or one long hold-off when asked for.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Each accepted result is compared with the oldest expected one.
	always @(posedge clk) begin : check_results
		postfix_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (postfix_q.size() == 0) begin
				fault_count++;
				if (fault_count <= MAX_REPORTS)
					$display("unexpected result: char=%h has=%b eor=%b err=%b",
						out_char, has_char, end_of_run, error);
			end else begin
				want = postfix_q.pop_front();
				if (out_char !== want.ch || has_char !== want.has ||
				    end_of_run !== want.eor || error !== want.err) begin
					fault_count++;
					if (fault_count <= MAX_REPORTS)
						$display({"mismatch: expected char=%h has=%b eor=%b err=%b,",
							" got char=%h has=%b eor=%b err=%b"},
							want.ch, want.has, want.eor, want.err,
							out_char, has_char, end_of_run, error);
				end
			end
		end
	end

	// Ends the run when nothing moves on either side for too long.
	initial begin : watchdog
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Field extremes, every operator, grouping and the error cases.
	task automatic test_directed();
		queue_text("A+b*C-0/9");
		send_expression();
		queue_text("z^Z^a");
		send_expression();
		// A close paren on an empty stack ends with an empty marker.
		queue_text(")");
		send_expression();
		// An open paren left at the flush is dropped.
		queue_text("(");
		send_expression();
		// Unknown characters are ignored but flag the run.
		expr_chars.push_back(8'h00);
		expr_chars.push_back(8'hFF);
		queue_text("9");
		send_expression();
		queue_text("(a-b)^c");
		send_expression();
	endtask

	// Fills the stack with powers, then pushes once more onto the full stack.
	task automatic test_overflow();
		int i;
		for (i = 0; i < STACK_DEPTH + 1; i++) expr_chars.push_back(CH_POW);
		expr_chars.push_back(CH_OPEN);
		queue_text("x");
		send_expression();
	endtask

	// Mostly well-formed expressions, some broken, some plain noise.
	task automatic test_random(input int send_pct, input int recv_pct, input int count);
		int start;
		int kind;
		int pos;
		int n;
		int i;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		start = items_sent;
		while (items_sent - start < count) begin
			kind = $urandom_range(0, 9);
			build_infix(2);
			if (kind == 8) begin
				pos = $urandom_range(0, expr_chars.size() - 1);
				case ($urandom_range(0, 4))
					0: expr_chars[pos] = CH_OPEN;
					1: expr_chars[pos] = CH_CLOSE;
					2: expr_chars[pos] = 8'($urandom_range(0, 255));
					3: expr_chars.push_back(rand_operator());
					default: if (expr_chars.size() > 1) expr_chars.delete(pos);
				endcase
			end else if (kind == 9) begin
				expr_chars.delete();
				n = $urandom_range(1, 6);
				for (i = 0; i < n; i++) expr_chars.push_back(8'($urandom_range(0, 255)));
			end
			send_expression();
		end
	endtask

	// The receiver holds off while the sender keeps offering requests.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b1;
		queue_text("(a+b)*c-d^e^f/g+h");
		send_expression();
		build_infix(2);
		send_expression();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 7;
		recv_idle_pct = 67;
		test_directed();
		test_overflow();
		test_random(7, 67, 140);
		test_random(67, 7, 140);
		test_random(0, 0, 140);
		test_backpressure();
		in_valid <= 1'b0;

		// Wait for every expected result, then a little longer for strays.
		while (postfix_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0 && postfix_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
